@@ rtl/core/mbp_pkg.sv @@
package mbp_pkg;

  // code and byte geometry
  localparam int unsigned CodeBits  = 32;
  localparam int unsigned LenBits   = 6;
  localparam int unsigned ByteBits  = 8;
  localparam int unsigned PendBits  = 7;
  localparam int unsigned CntBits   = 3;
  localparam int unsigned MaxBytes  = 4;
  localparam int unsigned WordBits  = CodeBits + ByteBits;

  localparam logic [LenBits-1:0] MaxLen = 6'd32;

  // item modes
  localparam logic ModePut   = 1'b0;
  localparam logic ModeFlush = 1'b1;

  // one queued group of completed bytes, first byte at index 0
  typedef struct packed {
    logic [MaxBytes-1:0][ByteBits-1:0] bytes;
    logic [1:0]                        last_idx;
  } mbp_entry_t;

  // queue fill status
  typedef struct packed {
    logic full;
    logic empty;
  } mbp_qstat_t;

  // partial byte held between items
  typedef struct packed {
    logic [PendBits-1:0] bits;
    logic [CntBits-1:0]  count;
  } mbp_pend_t;

endpackage

@@ rtl/core/mbp_item_if.sv @@
interface mbp_item_if;
  logic        valid;
  logic        ready;
  logic        mode;
  logic [5:0]  code_length;
  logic [31:0] code_value;

  modport source (output valid, output mode, output code_length, output code_value,
                  input ready);
  modport sink (input valid, input mode, input code_length, input code_value,
                output ready);
endinterface

@@ rtl/core/mbp_result_if.sv @@
interface mbp_result_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       last_of_item;

  modport source (output valid, output out_byte, output last_of_item, input ready);
  modport sink (input valid, input out_byte, input last_of_item, output ready);
endinterface

@@ rtl/core/mbp_front.sv @@
module mbp_front
  import mbp_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  mbp_item_if.sink         item,
  input  mbp_qstat_t       qstat,
  output logic             push,
  output mbp_entry_t       push_entry,
  output mbp_pend_t        pend
);

  logic                 accept;
  logic                 is_flush;
  logic [LenBits-1:0]   len_sat;
  logic [LenBits-1:0]   eff_len;
  logic [CodeBits-1:0]  val_al;
  logic [WordBits-1:0]  word;
  logic [LenBits-1:0]   total;
  logic [CntBits-1:0]   nbytes;
  logic [CntBits-1:0]   rem;
  logic [ByteBits-1:0]  w_bytes [MaxBytes+1];
  logic [ByteBits-1:0]  part;
  mbp_pend_t            pend_next;

  // take items whenever the queue has room
  assign item.ready = !qstat.full;
  assign accept     = item.valid && item.ready;
  assign is_flush   = (item.mode == ModeFlush);

  // saturate length, flush appends nothing
  assign len_sat = (item.code_length > MaxLen) ? MaxLen : item.code_length;
  assign eff_len = is_flush ? '0 : len_sat;

  // code bits left-aligned, unused high bits drop off the top
  assign val_al = is_flush ? '0 : (item.code_value << (MaxLen - len_sat));

  // pending bits then code bits, oldest bit in the msb
  assign word = ({pend.bits, {(WordBits-PendBits){1'b0}}} << (3'd7 - pend.count))
              | ({val_al, {ByteBits{1'b0}}} >> pend.count);

  assign total  = {{(LenBits-CntBits){1'b0}}, pend.count} + eff_len;
  assign nbytes = total[LenBits-1:CntBits];
  assign rem    = total[CntBits-1:0];

  // byte lanes of the combined word
  for (genvar i = 0; i <= MaxBytes; i++) begin : g_lane
    assign w_bytes[i] = word[WordBits-1-ByteBits*i -: ByteBits];
  end

  for (genvar i = 0; i < MaxBytes; i++) begin : g_entry
    assign push_entry.bytes[i] = w_bytes[i];
  end

  // leftover bits sit in the lane after the last full byte
  assign part = w_bytes[nbytes];

  assign push_entry.last_idx = is_flush ? 2'd0 : 2'(nbytes - 3'd1);
  assign push = accept && (is_flush ? (pend.count != '0) : (nbytes != '0));

  // next partial-byte state
  always_comb begin
    if (is_flush) begin
      pend_next = '0;
    end else begin
      pend_next.bits  = PendBits'(part >> (4'd8 - {1'b0, rem}));
      pend_next.count = rem;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pend <= '0;
    end else if (accept) begin
      pend <= pend_next;
    end
  end

endmodule

@@ rtl/core/mbp_queue.sv @@
module mbp_queue
  import mbp_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  input  mbp_entry_t  push_entry,
  input  logic        pop,
  output mbp_entry_t  head,
  output mbp_qstat_t  qstat
);

  mbp_entry_t mem [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] fill;

  assign head        = mem[rd_ptr];
  assign qstat.full  = (fill == 2'd2);
  assign qstat.empty = (fill == 2'd0);

  // entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_entry;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      fill <= fill + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

@@ rtl/core/mbp_back.sv @@
module mbp_back
  import mbp_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  mbp_entry_t  head,
  input  mbp_qstat_t  qstat,
  output logic        pop,
  mbp_result_if.source result
);

  logic       load;
  logic       at_last;
  logic [1:0] idx;
  logic       o_valid;
  logic [7:0] o_byte;
  logic       o_last;

  // refill the output register when empty or being taken
  assign load    = !qstat.empty && (!o_valid || result.ready);
  assign at_last = (idx == head.last_idx);
  assign pop     = load && at_last;

  assign result.valid        = o_valid;
  assign result.out_byte     = o_byte;
  assign result.last_of_item = o_last;

  // byte index within the head entry
  always_ff @(posedge clk) begin
    if (rst) begin
      idx <= 2'd0;
    end else if (load) begin
      idx <= at_last ? 2'd0 : idx + 2'd1;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      o_valid <= 1'b0;
    end else if (load) begin
      o_valid <= 1'b1;
    end else if (result.ready) begin
      o_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      o_byte <= head.bytes[idx];
      o_last <= at_last;
    end
  end

endmodule

@@ rtl/core/msb_first_bit_packer.sv @@
// channel  | role   | payload                                  | transaction
// item     | sink   | mode, code_length[5:0], code_value[31:0] | valid && ready
// result   | source | out_byte[7:0], last_of_item              | valid && ready
//
// an item yields 0 to 4 bytes; items follow back to back while the queue has room
// the byte-wide result port sets the rate: an item with n bytes takes n handshakes there
// a 2-entry queue between the packing front and the byte sequencer absorbs bursts
// item.ready drops only while the queue is full; result stalls never stop the front early
// synchronous active-high rst clears the partial byte, queue and output register
module msb_first_bit_packer
  import mbp_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  mbp_item_if.sink     item,
  mbp_result_if.source result
);

  logic       push;
  logic       pop;
  mbp_entry_t push_entry;
  mbp_entry_t head;
  mbp_qstat_t qstat;
  mbp_pend_t  pend;

  // packing front
  mbp_front u_front (
    .clk        (clk),
    .rst        (rst),
    .item       (item),
    .qstat      (qstat),
    .push       (push),
    .push_entry (push_entry),
    .pend       (pend)
  );

  // byte group queue
  mbp_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .head       (head),
    .qstat      (qstat)
  );

  // byte sequencer
  mbp_back u_back (
    .clk    (clk),
    .rst    (rst),
    .head   (head),
    .qstat  (qstat),
    .pop    (pop),
    .result (result)
  );

  // checks
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push |-> !qstat.full) else $error("queue written while full");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    pop |-> !qstat.empty) else $error("queue read while empty");

  a_pend_clean: assert property (@(posedge clk) disable iff (rst)
    (pend.bits >> pend.count) == '0) else $error("stale bits above pending count");

  a_flush_clears: assert property (@(posedge clk) disable iff (rst)
    (item.valid && item.ready && item.mode == ModeFlush) |=> pend.count == '0)
    else $error("flush left pending bits");

endmodule

@@ tb/msb_first_bit_packer_tb.sv @@
`timescale 1ns / 100ps

module msb_first_bit_packer_tb;
  import mbp_pkg::*;

  localparam int CycleLimit  = 300000;
  localparam int DrainCycles = 20;
  localparam int HoldCycles  = 80;

  // one expected output byte
  typedef struct {
    logic [7:0] data;
    logic       last;
  } packed_byte_t;

  logic clk = 1'b0;
  logic rst;

  mbp_item_if   item_ch ();
  mbp_result_if result_ch ();

  msb_first_bit_packer dut (
    .clk    (clk),
    .rst    (rst),
    .item   (item_ch),
    .result (result_ch)
  );

  // expected byte stream and the predictor's partial byte
  packed_byte_t packed_byte_q[$];
  logic [6:0]   part_bits;
  logic [2:0]   part_count;

  // run control and statistics
  bit src_idle     = 1'b0;
  bit sink_idle    = 1'b0;
  int hold_request = 0;
  int stall_left   = 0;
  int cycle_count  = 0;
  int error_count  = 0;
  int put_count    = 0;
  int flush_count  = 0;
  int byte_count   = 0;
  int stall_seen   = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // gap length: mostly short, now and then a long one
  function automatic int pick_gap();
    if ($urandom_range(0, 99) < 10) begin
      return $urandom_range(8, 30);
    end
    return $urandom_range(1, 3);
  endfunction

  // advance the partial byte by one item and queue every byte it completes
  function automatic void pack_item(input logic m, input logic [5:0] len,
                                    input logic [31:0] val);
    logic [39:0]  acc;
    int unsigned  n;
    int unsigned  total;
    int unsigned  nbytes;
    packed_byte_t pb;
    if (m == ModeFlush) begin
      flush_count++;
      if (part_count != 3'd0) begin
        pb.data = 8'({1'b0, part_bits} << (8 - part_count));
        pb.last = 1'b1;
        packed_byte_q.push_back(pb);
      end
      part_bits  = '0;
      part_count = '0;
      return;
    end
    put_count++;
    // lengths beyond 32 saturate
    n = (len > MaxLen) ? 32 : len;
    if (n == 0) begin
      return;
    end
    acc    = (40'(part_bits) << n) | (40'(val) & ((40'd1 << n) - 40'd1));
    total  = part_count + n;
    nbytes = total / 8;
    for (int unsigned k = 0; k < nbytes; k++) begin
      pb.data = 8'(acc >> (total - 8 * (k + 1)));
      pb.last = (k + 1 == nbytes);
      packed_byte_q.push_back(pb);
    end
    part_count = 3'(total % 8);
    part_bits  = 7'(acc & ((40'd1 << part_count) - 40'd1));
  endfunction

  // predict on each item transaction, check each result transaction
  always @(posedge clk) begin
    if (rst) begin
      part_bits  = '0;
      part_count = '0;
    end else begin
      if (item_ch.valid && item_ch.ready) begin
        pack_item(item_ch.mode, item_ch.code_length, item_ch.code_value);
      end
      if (result_ch.valid && result_ch.ready) begin
        byte_count++;
        if (packed_byte_q.size() == 0) begin
          error_count++;
          $display("%0t: unexpected byte: expected none, actual 0x%02h last %0b",
                   $time, result_ch.out_byte, result_ch.last_of_item);
        end else begin
          packed_byte_t pb;
          pb = packed_byte_q.pop_front();
          if (result_ch.out_byte !== pb.data) begin
            error_count++;
            $display("%0t: out_byte mismatch: expected 0x%02h, actual 0x%02h",
                     $time, pb.data, result_ch.out_byte);
          end
          if (result_ch.last_of_item !== pb.last) begin
            error_count++;
            $display("%0t: last_of_item mismatch: expected %0b, actual %0b",
                     $time, pb.last, result_ch.last_of_item);
          end
        end
      end
    end
  end

  // result receiver: random stalls plus an optional long hold-off
  always @(posedge clk) begin
    if (rst) begin
      result_ch.ready <= 1'b0;
      stall_left = 0;
    end else if (stall_left > 0) begin
      result_ch.ready <= 1'b0;
      stall_left--;
    end else if (hold_request > 0) begin
      result_ch.ready <= 1'b0;
      stall_left   = hold_request - 1;
      hold_request = 0;
    end else if (sink_idle && $urandom_range(0, 3) == 0) begin
      result_ch.ready <= 1'b0;
      stall_left = pick_gap() - 1;
    end else begin
      result_ch.ready <= 1'b1;
    end
  end

  // count input stalls caused by a full block
  always @(posedge clk) begin
    if (!rst && item_ch.valid && !item_ch.ready) begin
      stall_seen++;
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CycleLimit) begin
      $display("%0t: timeout with %0d bytes outstanding", $time, packed_byte_q.size());
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // offer one item and wait for its transaction
  task automatic send_item(input logic m, input logic [5:0] len, input logic [31:0] val);
    int gap;
    gap = (src_idle && $urandom_range(0, 2) == 0) ? pick_gap() : 0;
    if (gap > 0) begin
      item_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    item_ch.valid       <= 1'b1;
    item_ch.mode        <= m;
    item_ch.code_length <= len;
    item_ch.code_value  <= val;
    @(posedge clk);
    while (!item_ch.ready) @(posedge clk);
  endtask

  task automatic send_random(input int count);
    int         r;
    logic       m;
    logic [5:0] len;
    for (int i = 0; i < count; i++) begin
      r = $urandom_range(0, 99);
      m = ModePut;
      if (r < 8) begin
        m   = ModeFlush;
        len = 6'($urandom);
      end else if (r < 12) begin
        len = 6'd0;
      end else if (r < 18) begin
        len = 6'($urandom_range(33, 63));
      end else if (r < 30) begin
        len = MaxLen;
      end else begin
        len = 6'($urandom_range(1, 31));
      end
      send_item(m, len, $urandom);
    end
  endtask

  // let the predictor see the last item first, then wait until every expected byte has come out
  task automatic wait_drained();
    item_ch.valid <= 1'b0;
    @(posedge clk);
    while (packed_byte_q.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
  endtask

  // edge cases: zero length, saturation, masking, padding, empty flush
  task automatic test_directed();
    src_idle  = 1'b0;
    sink_idle = 1'b0;
    send_item(ModePut, 6'd0, 32'hFFFF_FFFF);
    send_item(ModeFlush, 6'd17, 32'h1234_5678);
    send_item(ModePut, 6'd8, 32'h0000_00A5);
    send_item(ModePut, 6'd32, 32'hFFFF_FFFF);
    send_item(ModePut, 6'd32, 32'h0000_0000);
    send_item(ModePut, 6'd3, 32'hFFFF_FFFD);
    send_item(ModeFlush, 6'd0, 32'h0000_0000);
    send_item(ModePut, 6'd63, 32'h8000_0001);
    send_item(ModePut, 6'd33, 32'hDEAD_BEEF);
    for (int i = 0; i < 9; i++) begin
      send_item(ModePut, 6'd1, 32'(i & 1));
    end
    send_item(ModePut, 6'd7, 32'h0000_0055);
    send_item(ModePut, 6'd32, 32'hC3A5_5A3C);
    send_item(ModeFlush, 6'd63, 32'hFFFF_FFFF);
    send_item(ModePut, 6'd31, 32'h7FFF_FFFF);
    send_item(ModePut, 6'd40, 32'h0F0F_F0F0);
    send_item(ModeFlush, 6'd32, 32'hAAAA_5555);
    wait_drained();
  endtask

  // random items at full rate on both sides
  task automatic test_streaming();
    src_idle  = 1'b0;
    sink_idle = 1'b0;
    send_random(40);
    wait_drained();
  endtask

  // random items with idle gaps on both channels
  task automatic test_idling();
    src_idle  = 1'b1;
    sink_idle = 1'b1;
    send_random(60);
    wait_drained();
  endtask

  // long receiver hold-off while full-length codes keep coming
  task automatic test_backpressure();
    src_idle     = 1'b0;
    sink_idle    = 1'b0;
    hold_request = HoldCycles;
    for (int i = 0; i < 8; i++) begin
      send_item(ModePut, MaxLen, $urandom);
    end
    send_item(ModeFlush, 6'd0, 32'h0000_0000);
    wait_drained();
  endtask

  initial begin
    rst <= 1'b1;
    item_ch.valid       <= 1'b0;
    item_ch.mode        <= ModePut;
    item_ch.code_length <= '0;
    item_ch.code_value  <= '0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_directed();
    test_streaming();
    test_idling();
    test_backpressure();

    $display("run covered %0d puts and %0d flushes, %0d bytes checked",
             put_count, flush_count, byte_count);
    $display("input stalled %0d cycles under backpressure, %0d mismatches",
             stall_seen, error_count);
    if (error_count == 0 && packed_byte_q.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

@@ msb_first_bit_packer.f @@
rtl/core/mbp_pkg.sv
rtl/core/mbp_item_if.sv
rtl/core/mbp_result_if.sv
rtl/core/mbp_front.sv
rtl/core/mbp_queue.sv
rtl/core/mbp_back.sv
rtl/core/msb_first_bit_packer.sv
tb/msb_first_bit_packer_tb.sv
